>>> rtl/mscc_pkg.sv
// Package for the minute stamp / calendar converter.
// Field widths, stage count, reciprocal constants for the constant dividers
// and the month offset table. No dependencies.
package mscc_pkg;

  // Pipeline depth: stage NUM_STAGES is the output register
  localparam int NUM_STAGES = 9;
  // Stage at which the build path has its stamp
  localparam int BUILD_DONE = 5;

  // Field widths
  localparam int STAMP_W = 32;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;

  // Request command codes
  typedef enum logic {CMD_SPLIT = 1'b0, CMD_BUILD = 1'b1} conv_cmd_e;

  // One enable or valid bit per stage
  typedef logic [NUM_STAGES:1] stage_vec_t;

  // Reciprocals: floor(c*x/D) = (x * ceil(2^S*c/D)) >> S, exact over the
  // operand range because x * (M*D - c*2^S) < 2^S.

  // stamp/1440 = (stamp>>5)/45, x < 2^27
  localparam int          DIV45_SH    = 33;
  localparam logic [27:0] DIV45_RECIP = 28'(((64'd1 << DIV45_SH) + 64'd44) / 64'd45);
  // n = 4*ell/146097, ell < 2^22
  localparam int          DIVN_SH     = 40;
  localparam logic [24:0] DIVN_RECIP  =
    25'(((64'd4 << DIVN_SH) + 64'd146096) / 64'd146097);
  // i = 4000*(ell2+1)/1461001, ell2+1 < 2^17
  localparam int          DIVI_SH     = 38;
  localparam logic [29:0] DIVI_RECIP  =
    30'(((64'd4000 << DIVI_SH) + 64'd1461000) / 64'd1461001);
  // j = 80*ell3/2447, ell3 < 2^16
  localparam int          DIVJ_SH     = 28;
  localparam logic [23:0] DIVJ_RECIP  = 24'(((64'd80 << DIVJ_SH) + 64'd2446) / 64'd2447);
  // k = j/11, j < 2^12
  localparam int          DIV11_SH    = 16;
  localparam logic [12:0] DIV11_RECIP = 13'(((64'd1 << DIV11_SH) + 64'd10) / 64'd11);
  // 2447*j/80, j < 2^12
  localparam int          DIVD_SH     = 19;
  localparam logic [23:0] DIVD_RECIP  = 24'(((64'd2447 << DIVD_SH) + 64'd79) / 64'd80);
  // |u|/100, |u| < 2^14
  localparam int          DIV100_SH   = 21;
  localparam logic [14:0] DIV100_RECIP = 15'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
  // minute of day / 60, value < 1440
  localparam int          HOUR_SH     = 16;
  localparam logic [10:0] HOUR_RECIP  = 11'd1093;

  // Day number bias of the split path
  localparam logic [21:0] SPLIT_BIAS   = 22'd68569;
  // 1440 fits 11 bits, enough for the minute-of-day remainder
  localparam logic [10:0] MIN_PER_DAY  = 11'd1440;
  localparam logic [31:0] MIN_PER_DAY_W = 32'd1440;

  // Supported date window of the build path
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1700;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9800;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

  // 367*(m-2-12a)/12 as a function of the month code, a = -1 for m <= 2
  function automatic logic [8:0] month_offset_f(input logic [MONTH_W-1:0] month);
    logic [8:0] ofs;
    case (month)
      4'd0:    ofs = 9'd305;
      4'd1:    ofs = 9'd336;
      4'd2:    ofs = 9'd367;
      4'd3:    ofs = 9'd30;
      4'd4:    ofs = 9'd61;
      4'd5:    ofs = 9'd91;
      4'd6:    ofs = 9'd122;
      4'd7:    ofs = 9'd152;
      4'd8:    ofs = 9'd183;
      4'd9:    ofs = 9'd214;
      4'd10:   ofs = 9'd244;
      4'd11:   ofs = 9'd275;
      4'd12:   ofs = 9'd305;
      4'd13:   ofs = 9'd336;
      4'd14:   ofs = 9'd367;
      default: ofs = 9'd397;
    endcase
    return ofs;
  endfunction

endpackage

>>> rtl/mscc_in_if.sv
// Input channel of the converter: valid/ready plus the request word.
// Depends on mscc_pkg for field widths.
interface mscc_in_if import mscc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [STAMP_W-1:0] in_stamp;
  logic [YEAR_W-1:0]  in_year;
  logic [MONTH_W-1:0] in_month;
  logic [DAY_W-1:0]   in_day;

  modport source (output valid, command, in_stamp, in_year, in_month, in_day,
                  input ready);
  modport sink   (input valid, command, in_stamp, in_year, in_month, in_day,
                  output ready);
endinterface

>>> rtl/mscc_out_if.sv
// Output channel of the converter: valid/ready plus the result word.
// Depends on mscc_pkg for field widths.
interface mscc_out_if import mscc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day;
  logic [HOUR_W-1:0]  out_hour;
  logic [STAMP_W-1:0] out_stamp;
  logic               out_of_range;

  modport source (output valid, out_year, out_month, out_day, out_hour, out_stamp,
                  out_of_range, input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_hour, out_stamp,
                  out_of_range, output ready);
endinterface

>>> rtl/mscc_split.sv
// Split datapath: minute stamp to year, month, day and hour, nine stages.
// Stage enables come from the top level; depends on mscc_pkg.
module mscc_split import mscc_pkg::*; (
  input  logic               clk_i,
  input  stage_vec_t         ld_i,
  input  logic [STAMP_W-1:0] stamp_i,
  output logic [YEAR_W-1:0]  year_o,
  output logic [MONTH_W-1:0] month_o,
  output logic [DAY_W-1:0]   day_o,
  output logic [HOUR_W-1:0]  hour_o
);

  // Stage 1: day count product, (stamp>>5) * 1/45
  logic [54:0] s1_prod_q;
  logic [10:0] s1_lo_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      s1_prod_q <= {28'd0, stamp_i[31:5]} * {27'd0, DIV45_RECIP};
      s1_lo_q   <= stamp_i[10:0];
    end
  end

  // Stage 2: biased day number and minute of day
  logic [21:0] s2_quo;
  logic [21:0] s2_ell_d, s2_ell_q;
  logic [10:0] s2_mod_d, s2_mod_q;

  assign s2_quo   = s1_prod_q[DIV45_SH +: 22];
  assign s2_ell_d = s2_quo + SPLIT_BIAS;
  assign s2_mod_d = s1_lo_q - (s2_quo[10:0] * MIN_PER_DAY);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      s2_ell_q <= s2_ell_d;
      s2_mod_q <= s2_mod_d;
    end
  end

  // Stage 3: 400-year cycle product and hour product
  logic [46:0] s3_nprod_q;
  logic [21:0] s3_hprod_q;
  logic [21:0] s3_ell_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      s3_nprod_q <= {25'd0, s2_ell_q} * {22'd0, DIVN_RECIP};
      s3_hprod_q <= {11'd0, s2_mod_q} * {11'd0, HOUR_RECIP};
      s3_ell_q   <= s2_ell_q;
    end
  end

  // Stage 4: cycle count n, day within the cycle, hour
  logic [6:0]  s4_n_d, s4_n_q;
  logic [24:0] s4_cyc;
  logic [22:0] s4_diff;
  logic [15:0] s4_ell2_q;
  logic [HOUR_W-1:0] s4_hour_d, s4_hour_q;

  assign s4_n_d    = s3_nprod_q[DIVN_SH +: 7];
  assign s4_cyc    = {18'd0, s4_n_d} * 25'd146097 + 25'd3;
  assign s4_diff   = {1'b0, s3_ell_q} - s4_cyc[24:2];
  assign s4_hour_d = s3_hprod_q[HOUR_SH +: HOUR_W];

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      s4_n_q    <= s4_n_d;
      s4_ell2_q <= s4_diff[15:0];
      s4_hour_q <= s4_hour_d;
    end
  end

  // Stage 5: year-in-cycle product
  logic [16:0] s5_x;
  logic [46:0] s5_iprod_q;
  logic [6:0]  s5_n_q;
  logic [15:0] s5_ell2_q;
  logic [HOUR_W-1:0] s5_hour_q;

  assign s5_x = {1'b0, s4_ell2_q} + 17'd1;

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      s5_iprod_q <= {30'd0, s5_x} * {17'd0, DIVI_RECIP};
      s5_n_q     <= s4_n_q;
      s5_ell2_q  <= s4_ell2_q;
      s5_hour_q  <= s4_hour_q;
    end
  end

  // Stage 6: year i and day within the year (from March)
  logic [8:0]  s6_i_d, s6_i_q;
  logic [19:0] s6_yterm;
  logic [17:0] s6_sum;
  logic [15:0] s6_ell3_q;
  logic [6:0]  s6_n_q;
  logic [HOUR_W-1:0] s6_hour_q;

  assign s6_i_d   = s5_iprod_q[DIVI_SH +: 9];
  assign s6_yterm = {11'd0, s6_i_d} * 20'd1461;
  assign s6_sum   = {2'b00, s5_ell2_q} + 18'd31 - s6_yterm[19:2];

  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      s6_i_q    <= s6_i_d;
      s6_ell3_q <= s6_sum[15:0];
      s6_n_q    <= s5_n_q;
      s6_hour_q <= s5_hour_q;
    end
  end

  // Stage 7: month index product
  logic [39:0] s7_jprod_q;
  logic [15:0] s7_ell3_q;
  logic [8:0]  s7_i_q;
  logic [6:0]  s7_n_q;
  logic [HOUR_W-1:0] s7_hour_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[7]) begin
      s7_jprod_q <= {24'd0, s6_ell3_q} * {16'd0, DIVJ_RECIP};
      s7_ell3_q  <= s6_ell3_q;
      s7_i_q     <= s6_i_q;
      s7_n_q     <= s6_n_q;
      s7_hour_q  <= s6_hour_q;
    end
  end

  // Stage 8: month index j, year carry and day offset products
  logic [11:0] s8_j_d, s8_j_q;
  logic [24:0] s8_kprod_q;
  logic [35:0] s8_dprod_q;
  logic [15:0] s8_ell3_q;
  logic [8:0]  s8_i_q;
  logic [6:0]  s8_n_q;
  logic [HOUR_W-1:0] s8_hour_q;

  assign s8_j_d = s7_jprod_q[DIVJ_SH +: 12];

  always_ff @(posedge clk_i) begin
    if (ld_i[8]) begin
      s8_j_q     <= s8_j_d;
      s8_kprod_q <= {13'd0, s8_j_d} * {12'd0, DIV11_RECIP};
      s8_dprod_q <= {24'd0, s8_j_d} * {12'd0, DIVD_RECIP};
      s8_ell3_q  <= s7_ell3_q;
      s8_i_q     <= s7_i_q;
      s8_n_q     <= s7_n_q;
      s8_hour_q  <= s7_hour_q;
    end
  end

  // Stage 9: final date fields, all taken modulo their widths
  logic [8:0]  s9_k;
  logic [16:0] s9_dterm;
  logic [YEAR_W-1:0]  s9_year_d, s9_year_q;
  logic [MONTH_W-1:0] s9_month_d, s9_month_q;
  logic [DAY_W-1:0]   s9_day_d, s9_day_q;
  logic [HOUR_W-1:0]  s9_hour_q;

  assign s9_k       = s8_kprod_q[DIV11_SH +: 9];
  assign s9_dterm   = s8_dprod_q[DIVD_SH +: 17];
  assign s9_day_d   = s8_ell3_q[4:0] - s9_dterm[4:0];
  assign s9_month_d = s8_j_q[3:0] + 4'd2 - (s9_k[3:0] * 4'd12);
  // 100*(n-49) + 6400 folds to 100*n + 1500
  assign s9_year_d  = {7'd0, s8_n_q} * 14'd100 + {5'd0, s8_i_q} + {5'd0, s9_k}
                      + 14'd1500;

  always_ff @(posedge clk_i) begin
    if (ld_i[9]) begin
      s9_year_q  <= s9_year_d;
      s9_month_q <= s9_month_d;
      s9_day_q   <= s9_day_d;
      s9_hour_q  <= s8_hour_q;
    end
  end

  assign year_o  = s9_year_q;
  assign month_o = s9_month_q;
  assign day_o   = s9_day_q;
  assign hour_o  = s9_hour_q;

endmodule

>>> rtl/mscc_build.sv
// Build datapath: year, month, day to minute stamp, five stages and a delay
// line up to the output stage. Stage enables from the top; depends on mscc_pkg.
module mscc_build import mscc_pkg::*; (
  input  logic               clk_i,
  input  stage_vec_t         ld_i,
  input  logic [YEAR_W-1:0]  year_i,
  input  logic [MONTH_W-1:0] month_i,
  input  logic [DAY_W-1:0]   day_i,
  output logic [STAMP_W-1:0] stamp_o,
  output logic               oor_o
);

  // Stage 1: month adjust a (-1 for Jan/Feb and codes below), shifted years
  logic               s1_aneg;
  logic signed [15:0] s1_v_d, s1_v_q;
  logic [15:0]        s1_u;
  logic [13:0]        s1_uabs_d, s1_uabs_q;
  logic               s1_uneg_q;
  logic [8:0]         s1_t2_q;
  logic [DAY_W-1:0]   s1_d_q;
  logic               s1_oor_d, s1_oor_q;

  assign s1_aneg   = (month_i < 4'd3);
  assign s1_v_d    = {2'b00, year_i} - 16'd1600 - {15'd0, s1_aneg};
  assign s1_u      = {2'b00, year_i} - 16'd1500 - {15'd0, s1_aneg};
  assign s1_uabs_d = s1_u[15] ? 14'(-s1_u) : s1_u[13:0];
  assign s1_oor_d  = (year_i < YEAR_MIN) || (year_i > YEAR_MAX) ||
                     (month_i == '0) || (month_i > MONTH_MAX) || (day_i == '0);

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      s1_v_q    <= s1_v_d;
      s1_uabs_q <= s1_uabs_d;
      s1_uneg_q <= s1_u[15];
      s1_t2_q   <= month_offset_f(month_i);
      s1_d_q    <= day_i;
      s1_oor_q  <= s1_oor_d;
    end
  end

  // Stage 2: 1461*v/4 truncated toward zero, century quotient product
  logic signed [25:0] s2_p1;
  logic signed [25:0] s2_adj;
  logic signed [23:0] s2_t1_q;
  logic [28:0]        s2_pu_q;
  logic               s2_uneg_q;
  logic [8:0]         s2_t2_q;
  logic [DAY_W-1:0]   s2_d_q;
  logic               s2_oor_q;

  assign s2_p1  = 26'(s1_v_q) * 26'sd1461;
  assign s2_adj = s2_p1 + (s2_p1[25] ? 26'sd3 : 26'sd0);

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      s2_t1_q   <= s2_adj[25:2];
      s2_pu_q   <= {15'd0, s1_uabs_q} * {14'd0, DIV100_RECIP};
      s2_uneg_q <= s1_uneg_q;
      s2_t2_q   <= s1_t2_q;
      s2_d_q    <= s1_d_q;
      s2_oor_q  <= s1_oor_q;
    end
  end

  // Stage 3: magnitude of the century term, partial day sum
  logic [7:0]         s3_c;
  logic [9:0]         s3_c3;
  logic [7:0]         s3_t3_q;
  logic signed [24:0] s3_part_d, s3_part_q;
  logic               s3_uneg_q;
  logic               s3_oor_q;

  assign s3_c      = s2_pu_q[DIV100_SH +: 8];
  assign s3_c3     = {2'b00, s3_c} * 10'd3;
  assign s3_part_d = 25'(s2_t1_q) + $signed({16'd0, s2_t2_q}) + $signed({20'd0, s2_d_q})
                     - 25'sd32075;

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      s3_t3_q   <= s3_c3[9:2];
      s3_part_q <= s3_part_d;
      s3_uneg_q <= s2_uneg_q;
      s3_oor_q  <= s2_oor_q;
    end
  end

  // Stage 4: day count, century term carries the sign of u
  logic signed [25:0] s4_days_d, s4_days_q;
  logic               s4_oor_q;

  assign s4_days_d = s3_uneg_q ? 26'(s3_part_q) + $signed({18'd0, s3_t3_q})
                               : 26'(s3_part_q) - $signed({18'd0, s3_t3_q});

  always_ff @(posedge clk_i) begin
    if (ld_i[4]) begin
      s4_days_q <= s4_days_d;
      s4_oor_q  <= s3_oor_q;
    end
  end

  // Stage BUILD_DONE onward: stamp = days*1440 mod 2^32, then a delay line
  logic [STAMP_W-1:0] tail_stamp_q [BUILD_DONE:NUM_STAGES];
  logic               tail_oor_q   [BUILD_DONE:NUM_STAGES];

  always_ff @(posedge clk_i) begin
    if (ld_i[BUILD_DONE]) begin
      tail_stamp_q[BUILD_DONE] <= 32'(s4_days_q) * MIN_PER_DAY_W;
      tail_oor_q[BUILD_DONE]   <= s4_oor_q;
    end
  end

  for (genvar s = BUILD_DONE + 1; s <= NUM_STAGES; s++) begin : g_tail
    always_ff @(posedge clk_i) begin
      if (ld_i[s]) begin
        tail_stamp_q[s] <= tail_stamp_q[s-1];
        tail_oor_q[s]   <= tail_oor_q[s-1];
      end
    end
  end

  assign stamp_o = tail_stamp_q[NUM_STAGES];
  assign oor_o   = tail_oor_q[NUM_STAGES];

endmodule

>>> rtl/minute_stamp_calendar_convert_top.sv
// Top level of the minute stamp / Gregorian calendar converter.
// Uses mscc_pkg, mscc_in_if, mscc_out_if, mscc_split and mscc_build.
//
// Usage:
//   item_i carries one request word: command 0 splits in_stamp (minutes since
//   the shifted day-number origin) into year, month, day and hour; command 1
//   builds a stamp from in_year, in_month, in_day and flags dates outside
//   1700..9800 / 1..12 / 1..31 in out_of_range. Fields not used by a command
//   read zero in the result word on result_o.
//   Both directions use valid/ready; a word moves on a clock edge with both
//   high.
//   Nine register stages; a word accepted into stage 1 is shown on result_o
//   from stage 9. Throughput is one word per cycle unless result_o stalls:
//   every constant divide is a reciprocal multiply spread over its own stages.
//   Stalls: each stage holds its word while the stage after it is full and
//   stalled, so bubbles are squeezed out and new words keep entering until
//   all nine stages hold a word; then item_i.ready drops.
//   Reset clears every stage valid bit; the pipeline comes up empty and ready.
module minute_stamp_calendar_convert_top import mscc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mscc_in_if.sink      item_i,
  mscc_out_if.source   result_o
);

  stage_vec_t ld;
  stage_vec_t v_d, v_q;
  stage_vec_t cmd_d, cmd_q;

  // Stage load enables: a stage takes a new word when empty or draining
  assign ld[NUM_STAGES] = !v_q[NUM_STAGES] || result_o.ready;
  for (genvar s = 1; s < NUM_STAGES; s++) begin : g_ld
    assign ld[s] = !v_q[s] || ld[s+1];
  end

  // Valid and command bits travel with the data
  assign v_d[1]   = ld[1] ? item_i.valid   : v_q[1];
  assign cmd_d[1] = ld[1] ? item_i.command : cmd_q[1];
  for (genvar s = 2; s <= NUM_STAGES; s++) begin : g_vld
    assign v_d[s]   = ld[s] ? v_q[s-1]   : v_q[s];
    assign cmd_d[s] = ld[s] ? cmd_q[s-1] : cmd_q[s];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign item_i.ready = ld[1];

  // Datapaths
  logic [YEAR_W-1:0]  split_year;
  logic [MONTH_W-1:0] split_month;
  logic [DAY_W-1:0]   split_day;
  logic [HOUR_W-1:0]  split_hour;
  logic [STAMP_W-1:0] build_stamp;
  logic               build_oor;

  mscc_split u_split (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .stamp_i (item_i.in_stamp),
    .year_o  (split_year),
    .month_o (split_month),
    .day_o   (split_day),
    .hour_o  (split_hour)
  );

  mscc_build u_build (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .year_i  (item_i.in_year),
    .month_i (item_i.in_month),
    .day_i   (item_i.in_day),
    .stamp_o (build_stamp),
    .oor_o   (build_oor)
  );

  // Output word: fields of the other command read zero
  logic out_cmd;
  logic out_build;
  assign out_cmd   = cmd_q[NUM_STAGES];
  assign out_build = (out_cmd == CMD_BUILD);

  assign result_o.valid        = v_q[NUM_STAGES];
  assign result_o.out_year     = out_build ? '0 : split_year;
  assign result_o.out_month    = out_build ? '0 : split_month;
  assign result_o.out_day      = out_build ? '0 : split_day;
  assign result_o.out_hour     = out_build ? '0 : split_hour;
  assign result_o.out_stamp    = out_build ? build_stamp : '0;
  assign result_o.out_of_range = out_build && build_oor;

  // Checks
  logic in_acc, out_acc;
  assign in_acc  = item_i.valid && item_i.ready;
  assign out_acc = result_o.valid && result_o.ready;

  // Input back-pressure only when every stage holds a word
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (&v_q))
    else $error("input stalled with an empty stage");

  // Occupancy follows accepted inputs and delivered results exactly
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) ==
      $past($countones(v_q)) + $past(int'(in_acc)) - $past(int'(out_acc))))
    else $error("word lost or duplicated in pipeline");

  // Any stamp splits to a real calendar date
  a_split_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !out_build) |->
      (result_o.out_month != '0) && (result_o.out_month <= MONTH_MAX) &&
      (result_o.out_day != '0) && (result_o.out_year >= 14'd1600))
    else $error("split produced an invalid date");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for minute_stamp_calendar_convert_top: minute stamp split and date build.
// Uses mscc_pkg, mscc_in_if and mscc_out_if; predicts every word and checks it in order.
module testbench import mscc_pkg::*; ();

  typedef struct {
    conv_cmd_e          command;
    logic [STAMP_W-1:0] stamp;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    bit                 drain_first;  // hold off until the pipe has drained
  } conv_req_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [STAMP_W-1:0] stamp;
    logic               out_of_range;
  } conv_res_t;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYC   = 20;
  localparam int RANDOM_WORDS = 800;
  localparam int FIRST_YEAR   = 1700;
  localparam int LAST_YEAR    = 9800;

  logic clk = 1'b0;
  logic rst_n;

  mscc_in_if  in_ch ();
  mscc_out_if res_ch ();

  minute_stamp_calendar_convert_top u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (in_ch),
    .result_o (res_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  conv_req_t conv_req_q[$];
  conv_res_t predicted_conv_q[$];
  conv_req_t shown_req;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  int        run_left;
  int        mismatch_cnt;
  int        cycle_cnt;

  // Day count to minute stamp, forward formula with truncating division
  function automatic logic [STAMP_W-1:0] build_minute_stamp(longint y, longint m, longint d);
    longint a;
    longint days;
    a    = (m - 14) / 12;
    days = (1461 * (y - 1600 + a)) / 4
         + (367 * (m - 2 - 12 * a)) / 12
         - (3 * ((y - 1500 + a) / 100)) / 4
         + d - 32075;
    return STAMP_W'(days * 1440);
  endfunction

  // Expected result word for one request word
  function automatic conv_res_t convert_word(conv_req_t req);
    conv_res_t   r;
    logic [31:0] ell, n, i, j, k;
    longint      y, m, d;
    r.year = '0; r.month = '0; r.day = '0; r.hour = '0;
    r.stamp = '0; r.out_of_range = 1'b0;
    if (req.command == CMD_SPLIT) begin
      // inverse day-number formula, 32-bit unsigned wrap throughout
      ell = req.stamp / 32'd1440 + 32'd68569;
      n   = (32'd4 * ell) / 32'd146097;
      ell = ell - (32'd146097 * n + 32'd3) / 32'd4;
      i   = (32'd4000 * (ell + 32'd1)) / 32'd1461001;
      ell = ell - (32'd1461 * i) / 32'd4 + 32'd31;
      j   = (32'd80 * ell) / 32'd2447;
      k   = j / 32'd11;
      r.day   = DAY_W'(ell - (32'd2447 * j) / 32'd80);
      r.month = MONTH_W'(j + 32'd2 - 32'd12 * k);
      r.year  = YEAR_W'(32'd100 * (n - 32'd49) + i + k + 32'd6400);
      r.hour  = HOUR_W'((req.stamp / 32'd60) % 32'd24);
    end else begin
      y = req.year;
      m = req.month;
      d = req.day;
      r.stamp = build_minute_stamp(y, m, d);
      r.out_of_range = (y < FIRST_YEAR || y > LAST_YEAR || m < 1 || m > 12 ||
                        d < 1 || d > 31);
    end
    return r;
  endfunction

  // Queue a split word; the date fields carry noise the block must ignore
  task automatic add_split(logic [STAMP_W-1:0] stamp);
    conv_req_t req;
    req.command     = CMD_SPLIT;
    req.stamp       = stamp;
    req.year        = YEAR_W'($urandom);
    req.month       = MONTH_W'($urandom);
    req.day         = DAY_W'($urandom);
    req.drain_first = 1'b0;
    conv_req_q.push_back(req);
  endtask

  // Queue a build word; the stamp field carries noise
  task automatic add_build(int y, int m, int d);
    conv_req_t req;
    req.command     = CMD_BUILD;
    req.stamp       = $urandom;
    req.year        = YEAR_W'(y);
    req.month       = MONTH_W'(m);
    req.day         = DAY_W'(d);
    req.drain_first = 1'b0;
    conv_req_q.push_back(req);
  endtask

  // Driver: bursts of words with random gaps, optional drain before a word
  always @(posedge clk or negedge rst_n) begin : driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predicted_conv_q.push_back(convert_word(shown_req));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (conv_req_q.size() != 0 &&
                     !(conv_req_q[0].drain_first && predicted_conv_q.size() != 0)) begin
          shown_req = conv_req_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.command  <= shown_req.command;
          in_ch.in_stamp <= shown_req.stamp;
          in_ch.in_year  <= shown_req.year;
          in_ch.in_month <= shown_req.month;
          in_ch.in_day   <= shown_req.day;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk or negedge rst_n) begin : monitor
    conv_res_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      run_left   = $urandom_range(1, 30);
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_conv_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result word with nothing expected", $time);
        end else begin
          want = predicted_conv_q.pop_front();
          if (res_ch.out_year !== want.year || res_ch.out_month !== want.month ||
              res_ch.out_day !== want.day || res_ch.out_hour !== want.hour ||
              res_ch.out_stamp !== want.stamp ||
              res_ch.out_of_range !== want.out_of_range) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $write("%0t: exp y=%0d m=%0d d=%0d h=%0d s=%h oor=%b",
                     $time, want.year, want.month, want.day, want.hour, want.stamp,
                     want.out_of_range);
              $display(" got y=%0d m=%0d d=%0d h=%0d s=%h oor=%b",
                       res_ch.out_year, res_ch.out_month, res_ch.out_day,
                       res_ch.out_hour, res_ch.out_stamp, res_ch.out_of_range);
            end
          end
        end
      end
      // stall pattern: runs of ready, then short or long stalls
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        run_left--;
        if (run_left <= 0) begin
          run_left   = $urandom_range(1, 30);
          stall_left = ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) :
                                                     $urandom_range(1, 3);
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    int sel;
    int y;
    int m;
    int d;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_SPLIT;
    in_ch.in_stamp = '0;
    in_ch.in_year  = '0;
    in_ch.in_month = '0;
    in_ch.in_day   = '0;
    res_ch.ready   = 1'b0;
    mismatch_cnt   = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: stamp extremes, hour and day boundaries
    add_split(32'h0000_0000);
    add_split(32'hFFFF_FFFF);
    add_split(32'd59);
    add_split(32'd60);
    add_split(32'd1439);
    add_split(32'd1440);
    add_split(32'h7FFF_FFFF);
    add_split(32'h8000_0000);
    // directed: window edges, out-of-range fields, leap days
    add_build(FIRST_YEAR, 1, 1);
    add_build(LAST_YEAR, 12, 31);
    add_build(FIRST_YEAR - 1, 6, 15);
    add_build(LAST_YEAR + 1, 1, 1);
    add_build(0, 0, 0);
    add_build(16383, 15, 31);
    add_build(2000, 0, 10);
    add_build(2000, 13, 10);
    add_build(2000, 5, 0);
    add_build(2000, 2, 29);
    add_build(1900, 2, 28);
    add_build(1600, 3, 1);
    add_build(2024, 12, 31);

    // random mix, mostly valid dates and full-range stamps
    for (int w = 0; w < RANDOM_WORDS; w++) begin
      sel = $urandom_range(0, 9);
      y = $urandom_range(FIRST_YEAR, LAST_YEAR);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
      if (sel <= 3)
        add_split($urandom);
      else if (sel == 4)
        add_split(build_minute_stamp(y, m, d) + $urandom_range(0, 2879) - 32'd1440);
      else if (sel <= 8)
        add_build(y, m, d);
      else
        add_build($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
      if (w == 0 || w == RANDOM_WORDS / 2)
        conv_req_q[conv_req_q.size() - 1].drain_first = 1'b1;
    end

    while (conv_req_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    while (predicted_conv_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (mismatch_cnt == 0 && predicted_conv_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
